[sv/gwc_pkg.sv]
// ----------------------------------------------------------------------------
// gwc_pkg
// Shared types, constants and helpers of the Gaussian window convolver.
// ----------------------------------------------------------------------------
package gwc_pkg;

	localparam int DEF_KSIZE    = 5;
	localparam int DEF_MAX_COLS = 1024;

	localparam int MAX_KW    = 5;   // widest window (odd)
	localparam int COLW      = 12;  // column field of a step descriptor
	localparam int DIMW      = 13;  // internal width of column and row counts
	localparam int CNTW      = 25;  // raster position counters
	localparam int PIXW      = 32;  // packed ARGB
	localparam int WGTW      = 16;  // Q0.16 weight
	localparam int CFG_IDXW  = 3;
	localparam int CFG_DATAW = 16;
	localparam int DQ_DEPTH  = 4;   // step queue between front and back
	localparam int OQ_DEPTH  = 8;   // result queue

	localparam logic [10:0]     RST_COLS  = 11'd1024;
	localparam logic [12:0]     RST_ROWS  = 13'd768;
	localparam logic [WGTW-1:0] RST_W0    = 16'hffff;
	localparam logic [DIMW-1:0] MAX_ROWS  = 13'd4096;
	localparam logic [7:0]      SAT_MAX   = 8'hff;

	typedef enum logic [CFG_IDXW-1:0] {
		CFG_IMAGE_COLS = 3'd0,
		CFG_IMAGE_ROWS = 3'd1,
		CFG_WEIGHT_D0  = 3'd2,
		CFG_WEIGHT_D1  = 3'd3,
		CFG_WEIGHT_D2  = 3'd4,
		CFG_WEIGHT_D4  = 3'd5,
		CFG_WEIGHT_D5  = 3'd6,
		CFG_WEIGHT_D8  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_alpha;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_alpha;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [WGTW-1:0] w_d0;
		logic [WGTW-1:0] w_d1;
		logic [WGTW-1:0] w_d2;
		logic [WGTW-1:0] w_d4;
		logic [WGTW-1:0] w_d5;
		logic [WGTW-1:0] w_d8;
	} weights_t;

	// One raster step handed from front to back.
	typedef struct packed {
		logic [PIXW-1:0]   pix;
		logic [COLW-1:0]   col;
		logic              emit;
		logic              last;
		logic [MAX_KW-1:0] rmask;
		logic [MAX_KW-1:0] cmask;
	} desc_t;

	// Weight of a tap by its squared distance from the centre.
	function automatic logic [WGTW-1:0] tap_weight(weights_t w, int dx, int dy);
		int d;
		d = dx * dx + dy * dy;
		case (d)
			0:       return w.w_d0;
			1:       return w.w_d1;
			2:       return w.w_d2;
			4:       return w.w_d4;
			5:       return w.w_d5;
			8:       return w.w_d8;
			default: return '0;
		endcase
	endfunction

endpackage

[sv/gwc_stream_if.sv]
// ----------------------------------------------------------------------------
// gwc_stream_if
// Valid/ready channel carrying one item per transfer.
// ----------------------------------------------------------------------------
interface gwc_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/gwc_ram.sv]
// ----------------------------------------------------------------------------
// gwc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/gwc_fifo.sv]
// ----------------------------------------------------------------------------
// gwc_fifo
// Small register FIFO with occupancy count (power-of-two depth).
// ----------------------------------------------------------------------------
module gwc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0]           mem_q [DEPTH];
	logic [AW-1:0]              wptr_q, rptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign rdata = mem_q[rptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == ($clog2(DEPTH+1))'(DEPTH));
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[sv/gwc_front.sv]
// ----------------------------------------------------------------------------
// gwc_front
// Accepts items, tracks raster position and builds step descriptors.
// ----------------------------------------------------------------------------
module gwc_front import gwc_pkg::*; #(
	parameter int KSIZE    = DEF_KSIZE,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [10:0]  image_cols,
	input  logic [12:0]  image_rows,
	gwc_stream_if.sink   pix_in,
	input  logic         dq_full,
	output logic         dq_push,
	output desc_t        dq_data
);
	localparam int HALF = KSIZE / 2;
	localparam int KW   = 2 * HALF + 1;
	localparam int CW   = $clog2(MAX_COLS);

	logic [DIMW-1:0] cols, rows;
	logic [CNTW-1:0] total, lag;
	logic [CNTW-1:0] q_q, out_cnt_q, cur_q, cur_out;
	logic [CW-1:0]   in_col_q, out_c_q, cur_in_col, cur_out_c;
	logic [DIMW-1:0] out_r_q, cur_out_r;
	logic            accept, restart, in_image, ignore, emit, last;
	logic            in_wrap, out_wrap;
	logic signed [DIMW+1:0] yy, xx;
	logic [MAX_KW-1:0] rmask, cmask;

	always_comb begin
		if (image_cols == '0) begin
			cols = DIMW'(1);
		end else if (DIMW'(image_cols) > DIMW'(MAX_COLS)) begin
			cols = DIMW'(MAX_COLS);
		end else begin
			cols = DIMW'(image_cols);
		end
		if (image_rows == '0) begin
			rows = DIMW'(1);
		end else if (image_rows > MAX_ROWS) begin
			rows = MAX_ROWS;
		end else begin
			rows = image_rows;
		end
	end

	assign total = CNTW'(cols) * CNTW'(rows);
	assign lag   = CNTW'(HALF) * CNTW'(cols) + CNTW'(HALF);

	// Restart an image whose result count already covers the new size.
	assign restart    = (out_cnt_q >= total);
	assign cur_q      = restart ? '0 : q_q;
	assign cur_out    = restart ? '0 : out_cnt_q;
	assign cur_in_col = restart ? '0 : in_col_q;
	assign cur_out_c  = restart ? '0 : out_c_q;
	assign cur_out_r  = restart ? '0 : out_r_q;

	assign in_image = (cur_q < total);
	assign ignore   = in_image & pix_in.data.req_type;
	assign emit     = (cur_q >= cur_out + lag);
	assign last     = emit && (cur_out + CNTW'(1) == total);
	assign in_wrap  = (DIMW'(cur_in_col) + DIMW'(1) >= cols);
	assign out_wrap = (DIMW'(cur_out_c) + DIMW'(1) >= cols);

	// Tap k covers offset HALF-k; drop taps that fall outside the image.
	always_comb begin
		rmask = '0;
		cmask = '0;
		yy    = '0;
		xx    = '0;
		for (int k = 0; k < KW; k++) begin
			yy = $signed({2'b00, cur_out_r}) + $signed((DIMW+2)'(HALF - k));
			xx = $signed((DIMW+2)'(cur_out_c)) + $signed((DIMW+2)'(HALF - k));
			rmask[k] = (yy >= 0) && (yy < $signed({2'b00, rows}));
			cmask[k] = (xx >= 0) && (xx < $signed({2'b00, cols}));
		end
	end

	assign pix_in.ready = !dq_full;
	assign accept       = pix_in.valid & pix_in.ready;
	assign dq_push      = accept & !ignore;

	always_comb begin
		dq_data.pix   = {pix_in.data.in_alpha, pix_in.data.in_red,
		                 pix_in.data.in_green, pix_in.data.in_blue};
		dq_data.col   = COLW'(cur_in_col);
		dq_data.emit  = emit;
		dq_data.last  = last;
		dq_data.rmask = rmask;
		dq_data.cmask = cmask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q       <= '0;
			out_cnt_q <= '0;
			in_col_q  <= '0;
			out_c_q   <= '0;
			out_r_q   <= '0;
		end else if (accept) begin
			if (ignore) begin
				q_q       <= cur_q;
				out_cnt_q <= cur_out;
				in_col_q  <= cur_in_col;
				out_c_q   <= cur_out_c;
				out_r_q   <= cur_out_r;
			end else if (last) begin
				q_q       <= '0;
				out_cnt_q <= '0;
				in_col_q  <= '0;
				out_c_q   <= '0;
				out_r_q   <= '0;
			end else begin
				q_q      <= cur_q + CNTW'(1);
				in_col_q <= in_wrap ? '0 : cur_in_col + CW'(1);
				if (emit) begin
					out_cnt_q <= cur_out + CNTW'(1);
					out_c_q   <= out_wrap ? '0 : cur_out_c + CW'(1);
					out_r_q   <= out_wrap ? cur_out_r + DIMW'(1) : cur_out_r;
				end else begin
					out_cnt_q <= cur_out;
					out_c_q   <= cur_out_c;
					out_r_q   <= cur_out_r;
				end
			end
		end
	end

`ifndef SYNTH
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		dq_push && dq_data.last |-> dq_data.emit)
		else $error("last flag on a step without result");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		dq_push && dq_data.last |=> (q_q == '0) && (out_cnt_q == '0))
		else $error("counters not cleared after final pixel");
`endif
endmodule

[sv/gwc_back.sv]
// ----------------------------------------------------------------------------
// gwc_back
// Line store, sliding window, weighted sums and result queue.
// ----------------------------------------------------------------------------
module gwc_back import gwc_pkg::*; #(
	parameter int KSIZE    = DEF_KSIZE,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  weights_t     weights,
	input  logic         dq_empty,
	input  desc_t        dq_data,
	output logic         dq_pop,
	gwc_stream_if.source pix_out
);
	localparam int HALF = KSIZE / 2;
	localparam int KW   = 2 * HALF + 1;
	localparam int CW   = $clog2(MAX_COLS);
	localparam int LW   = (KW - 1) * PIXW;
	localparam int PRW  = 8 + WGTW;
	localparam int SW   = PRW + 3;
	localparam int ACCW = SW + 3;
	localparam int OCW  = $clog2(OQ_DEPTH + 1);
	localparam int OW   = $bits(out_item_t);

	logic [LW-1:0]   ram_rdata, lines, wdata, wb_q;
	logic [PIXW-1:0] stack [KW];
	logic [PIXW-1:0] win_q [KW][KW];
	desc_t           desc_s1;
	logic            vld_s1, vld_s2, vld_s3, vld_s4, fwd_s1;
	logic            emit_s2, emit_s3, emit_s4, last_s2, last_s3, last_s4;
	logic [MAX_KW-1:0] rmask_s2, cmask_s2;
	logic [PRW-1:0]  prod_s3 [4][KW][KW];
	logic [SW-1:0]   csum_d [4][KW];
	logic [SW-1:0]   csum_s4 [4][KW];
	logic [ACCW-1:0] acc [4];
	logic [7:0]      sat [4];
	logic [OCW-1:0]  of_count;
	logic [OCW:0]    occ;
	logic            of_push, of_empty, of_full;
	logic [OW-1:0]   of_rdata;
	out_item_t       oitem;

	// Take a step only when the result queue has room for all in flight.
	assign occ    = (OCW+1)'(of_count) + (OCW+1)'(vld_s1) + (OCW+1)'(vld_s2)
	              + (OCW+1)'(vld_s3) + (OCW+1)'(vld_s4);
	assign dq_pop = !dq_empty && (occ < (OCW+1)'(OQ_DEPTH));

	gwc_ram #(.WIDTH(LW), .DEPTH(MAX_COLS)) u_lines (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (desc_s1.col[CW-1:0]),
		.wdata (wdata),
		.raddr (dq_data.col[CW-1:0]),
		.rdata (ram_rdata)
	);

	// Stack the column: new pixel on top, older rows below; push rows down.
	always_comb begin
		lines    = fwd_s1 ? wb_q : ram_rdata;
		stack[0] = desc_s1.pix;
		wdata    = '0;
		wdata[PIXW-1:0] = desc_s1.pix;
		for (int i = 0; i < KW - 1; i++) begin
			stack[i+1] = lines[i*PIXW +: PIXW];
		end
		for (int i = 1; i < KW - 1; i++) begin
			wdata[i*PIXW +: PIXW] = lines[(i-1)*PIXW +: PIXW];
		end
	end

	always_ff @(posedge clk) begin
		if (dq_pop) begin
			desc_s1 <= dq_data;
		end
		if (vld_s1) begin
			wb_q     <= wdata;
			emit_s2  <= desc_s1.emit;
			last_s2  <= desc_s1.last;
			rmask_s2 <= desc_s1.rmask;
			cmask_s2 <= desc_s1.cmask;
		end
		emit_s3 <= emit_s2;
		last_s3 <= last_s2;
		emit_s4 <= emit_s3;
		last_s4 <= last_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			fwd_s1 <= 1'b0;
			for (int j = 0; j < KW; j++) begin
				for (int k = 0; k < KW; k++) begin
					win_q[j][k] <= '0;
				end
			end
		end else begin
			vld_s1 <= dq_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			// Line RAM reads old data when the same column is written now.
			fwd_s1 <= dq_pop && vld_s1 && (dq_data.col[CW-1:0] == desc_s1.col[CW-1:0]);
			if (vld_s1) begin
				win_q[0] <= stack;
				for (int j = 1; j < KW; j++) begin
					win_q[j] <= win_q[j-1];
				end
			end
		end
	end

	// Window column j holds offset HALF-j, row k offset HALF-k.
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 4; ch++) begin
			for (int j = 0; j < KW; j++) begin
				for (int k = 0; k < KW; k++) begin
					prod_s3[ch][j][k] <= (rmask_s2[k] & cmask_s2[j])
						? PRW'(win_q[j][k][PIXW-8*(ch+1) +: 8])
						  * PRW'(tap_weight(weights, HALF - j, HALF - k))
						: '0;
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			for (int j = 0; j < KW; j++) begin
				csum_d[ch][j] = '0;
				for (int k = 0; k < KW; k++) begin
					csum_d[ch][j] = csum_d[ch][j] + SW'(prod_s3[ch][j][k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		csum_s4 <= csum_d;
	end

	// Floor the Q16 sum and clip at full scale.
	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			acc[ch] = '0;
			for (int j = 0; j < KW; j++) begin
				acc[ch] = acc[ch] + ACCW'(csum_s4[ch][j]);
			end
			if (acc[ch][ACCW-1:16] > (ACCW-16)'(SAT_MAX)) begin
				sat[ch] = SAT_MAX;
			end else begin
				sat[ch] = acc[ch][23:16];
			end
		end
		oitem.out_alpha = sat[0];
		oitem.out_red   = sat[1];
		oitem.out_green = sat[2];
		oitem.out_blue  = sat[3];
		oitem.out_last  = last_s4;
	end

	assign of_push = vld_s4 & emit_s4;

	gwc_fifo #(.WIDTH(OW), .DEPTH(OQ_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (of_push),
		.wdata  (OW'(oitem)),
		.pop    (pix_out.valid & pix_out.ready),
		.rdata  (of_rdata),
		.empty  (of_empty),
		.full   (of_full),
		.count  (of_count)
	);

	assign pix_out.valid = !of_empty;
	assign pix_out.data  = out_item_t'(of_rdata);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		of_push |-> !of_full)
		else $error("result queue overflow");
	a_fwd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> $past(vld_s1))
		else $error("line bypass without preceding write");
`endif
endmodule

[sv/gaussian_window_convolver.sv]
// ----------------------------------------------------------------------------
// gaussian_window_convolver
// KSIZE x KSIZE Gaussian blur on a raster ARGB pixel stream.
// ----------------------------------------------------------------------------
// Send pixels of one image in raster order on pix_in (req_type 0); each
// accepted item advances one raster step and, once the stream is HALF rows
// and HALF columns ahead of a position, pix_out delivers the blurred pixel
// for that position, in raster order, out_last marking the final one.
// After the last image pixel, send flush items (req_type 1) to step past
// the end until out_last appears: HALF*cols + HALF of them. A flush inside
// the image is dropped without effect; a pixel past the end acts as flush.
// Throughput is one item per clock while the step queue has room: the
// column line store is a single one-write/one-read RAM of (KSIZE-1) packed
// rows by MAX_COLS, read and written once per step, and the 25-tap window
// feeds parallel multipliers. A four-deep step queue separates the input
// side from the datapath, and an eight-deep result queue holds finished
// pixels so the input keeps flowing while the output stalls, until both
// queues fill. Change image_cols or image_rows only between images.
// ----------------------------------------------------------------------------
module gaussian_window_convolver import gwc_pkg::*; #(
	parameter int KSIZE    = DEF_KSIZE,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gwc_stream_if.sink           pix_in,
	gwc_stream_if.source         pix_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDXW-1:0]  cfg_index,
	input  logic [CFG_DATAW-1:0] cfg_data
);
	localparam int DW = $bits(desc_t);

	logic [10:0] cols_q;
	logic [12:0] rows_q;
	weights_t    weights_q;
	logic        dq_push, dq_pop, dq_full, dq_empty;
	desc_t       dq_wdata;
	logic [DW-1:0] dq_rdata;
	logic [$clog2(DQ_DEPTH+1)-1:0] dq_count;

	// Configuration registers; hold until rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= RST_COLS;
			rows_q    <= RST_ROWS;
			weights_q <= '{RST_W0, '0, '0, '0, '0, '0};
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_COLS: cols_q         <= cfg_data[10:0];
				CFG_IMAGE_ROWS: rows_q         <= cfg_data[12:0];
				CFG_WEIGHT_D0:  weights_q.w_d0 <= cfg_data;
				CFG_WEIGHT_D1:  weights_q.w_d1 <= cfg_data;
				CFG_WEIGHT_D2:  weights_q.w_d2 <= cfg_data;
				CFG_WEIGHT_D4:  weights_q.w_d4 <= cfg_data;
				CFG_WEIGHT_D5:  weights_q.w_d5 <= cfg_data;
				CFG_WEIGHT_D8:  weights_q.w_d8 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: classify each transfer and build a raster step.
	gwc_front #(.KSIZE(KSIZE), .MAX_COLS(MAX_COLS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image_cols (cols_q),
		.image_rows (rows_q),
		.pix_in     (pix_in),
		.dq_full    (dq_full),
		.dq_push    (dq_push),
		.dq_data    (dq_wdata)
	);

	// Step queue lets front and back stall independently.
	gwc_fifo #(.WIDTH(DW), .DEPTH(DQ_DEPTH)) u_step_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dq_push),
		.wdata  (DW'(dq_wdata)),
		.pop    (dq_pop),
		.rdata  (dq_rdata),
		.empty  (dq_empty),
		.full   (dq_full),
		.count  (dq_count)
	);

	// Back: line store, window, multiply-accumulate, result queue.
	gwc_back #(.KSIZE(KSIZE), .MAX_COLS(MAX_COLS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.weights  (weights_q),
		.dq_empty (dq_empty),
		.dq_data  (desc_t'(dq_rdata)),
		.dq_pop   (dq_pop),
		.pix_out  (pix_out)
	);

`ifndef SYNTH
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		dq_empty |-> (dq_count == '0))
		else $error("step queue empty flag disagrees with count");
`endif
endmodule

[tb/gaussian_window_convolver_tb.sv]
// ----------------------------------------------------------------------------
// gaussian_window_convolver_tb
// Self-checking bench for the Gaussian window convolver: a short table of
// directed rows, a saturation image, random images of random sizes and weights;
// each result checked against a behavioral blur of the stream or a typed value.
// ----------------------------------------------------------------------------
module gaussian_window_convolver_tb;
	import gwc_pkg::*;

	localparam int KS       = 5;
	localparam int HALF     = KS / 2;
	localparam int NCOLS    = 1024;
	localparam int RING     = KS * NCOLS;
	localparam int IDLE_LIM = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDXW-1:0]  cfg_index;
	logic [CFG_DATAW-1:0] cfg_data;

	gwc_stream_if #(.item_t(in_item_t))  pix_in ();
	gwc_stream_if #(.item_t(out_item_t)) pix_out ();

	gaussian_window_convolver u_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_in(pix_in.sink), .pix_out(pix_out.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// Shadow of the block: registers, line store and raster counters.
	logic [10:0] img_cols;
	logic [12:0] img_rows;
	logic [15:0] wgt [6];
	logic [31:0] pix_ring [RING];
	int unsigned pos_col, pos_row, done_cnt;

	out_item_t   blur_q [$];
	int          err_cnt, idle_cycles, in_sent;
	bit          timed_out;

	// Directed rows: item plus an optional typed-in expected result.
	typedef struct {
		in_item_t  item;
		bit        has_exp;
		out_item_t exp_res;
	} drow_t;

	function automatic logic [15:0] weight_of(int d);
		case (d)
			0: return wgt[0];
			1: return wgt[1];
			2: return wgt[2];
			4: return wgt[3];
			5: return wgt[4];
			8: return wgt[5];
			default: return '0;
		endcase
	endfunction

	function automatic logic [7:0] sat_floor(longint unsigned acc);
		longint unsigned v;
		v = acc >> 16;
		return (v > 255) ? 8'hff : v[7:0];
	endfunction

	// Advance the shadow by one accepted item; push the blurred pixel if due.
	task automatic blur_step(input in_item_t it);
		int unsigned cols, rows, total, lag, q, r, c;
		int yy, xx;
		longint unsigned acc [4];
		logic [31:0] px;
		logic [15:0] w;
		out_item_t o;
		cols = (img_cols < 1) ? 1 : ((img_cols > NCOLS) ? NCOLS : img_cols);
		rows = (img_rows < 1) ? 1 : ((img_rows > 4096) ? 4096 : img_rows);
		total = cols * rows;
		lag = HALF * cols + HALF;
		if (done_cnt >= total) begin
			pos_col = 0; pos_row = 0; done_cnt = 0;
		end
		q = pos_row * cols + pos_col;
		if (q < total) begin
			// flush inside the image: drop it
			if (it.req_type) return;
			pix_ring[q % RING] = {it.in_alpha, it.in_red, it.in_green, it.in_blue};
		end
		pos_col++;
		if (pos_col >= cols) begin
			pos_col = 0;
			pos_row = (pos_row + 1) & 13'h1fff;
		end
		if (q < done_cnt + lag) return;
		r = done_cnt / cols;
		c = done_cnt % cols;
		for (int k = 0; k < 4; k++) acc[k] = 0;
		for (int dy = -HALF; dy <= HALF; dy++) begin
			yy = int'(r) + dy;
			if (yy < 0 || yy >= int'(rows)) continue;
			for (int dx = -HALF; dx <= HALF; dx++) begin
				xx = int'(c) + dx;
				if (xx < 0 || xx >= int'(cols)) continue;
				w = weight_of(dx * dx + dy * dy);
				px = pix_ring[(yy * cols + xx) % RING];
				for (int k = 0; k < 4; k++)
					acc[k] += longint'(px[31 - 8 * k -: 8]) * w;
			end
		end
		done_cnt++;
		o.out_alpha = sat_floor(acc[0]);
		o.out_red   = sat_floor(acc[1]);
		o.out_green = sat_floor(acc[2]);
		o.out_blue  = sat_floor(acc[3]);
		o.out_last  = (done_cnt == total);
		blur_q.push_back(o);
		if (o.out_last) begin
			pos_col = 0; pos_row = 0; done_cnt = 0;
		end
	endtask

	task automatic note_mismatch(input out_item_t exp_v, input out_item_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch: expected a=%0d r=%0d g=%0d b=%0d last=%0d, got a=%0d r=%0d g=%0d b=%0d last=%0d",
				exp_v.out_alpha, exp_v.out_red, exp_v.out_green, exp_v.out_blue,
				exp_v.out_last, got.out_alpha, got.out_red, got.out_green,
				got.out_blue, got.out_last);
	endtask

	// Drop valid on the input side; called at a falling edge.
	task automatic hold_input();
		pix_in.valid <= 1'b0;
		pix_in.data <= in_item_t'({1'b0, $urandom});
	endtask

	// Write one register; only called while the block is idle.
	task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] val);
		hold_input();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IMAGE_COLS: img_cols = val[10:0];
			CFG_IMAGE_ROWS: img_rows = val[12:0];
			CFG_WEIGHT_D0:  wgt[0] = val;
			CFG_WEIGHT_D1:  wgt[1] = val;
			CFG_WEIGHT_D2:  wgt[2] = val;
			CFG_WEIGHT_D4:  wgt[3] = val;
			CFG_WEIGHT_D5:  wgt[4] = val;
			CFG_WEIGHT_D8:  wgt[5] = val;
			default: ;
		endcase
	endtask

	// Send one item after a random gap; hold valid until the transfer.
	task automatic send_item(input in_item_t it, input bit no_gap);
		int gap;
		bit rdy;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			hold_input();
			repeat (gap) @(negedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.data <= it;
		// ready only moves at the rising edge: read it ahead of that edge
		forever begin
			rdy = pix_in.ready;
			@(posedge clk);
			if (rdy) break;
			@(negedge clk);
		end
		blur_step(it);
		in_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		hold_input();
		while (blur_q.size() != 0 && !timed_out) @(negedge clk);
		// a trailing ignored flush may still be in the pipe
		repeat (20) @(negedge clk);
	endtask

	function automatic in_item_t rand_pixel();
		in_item_t it;
		it = in_item_t'({1'b0, $urandom});
		it.req_type = 1'b0;
		return it;
	endfunction

	// Feed a full image with random content, then flush it out.
	task automatic run_image(input int cols, input int rows);
		in_item_t it;
		for (int k = 0; k < cols * rows; k++) begin
			it = rand_pixel();
			// an occasional stray flush inside the image
			if ($urandom_range(0, 15) == 0) begin
				it.req_type = 1'b1;
				send_item(it, 1'b0);
				it.req_type = 1'b0;
			end
			send_item(it, 1'b0);
		end
		while (done_cnt != 0 || pos_col != 0 || pos_row != 0) begin
			it = in_item_t'({1'b0, $urandom});
			// a pixel past the end behaves as a flush
			if ($urandom_range(0, 3) != 0) it.req_type = 1'b1;
			send_item(it, 1'b0);
		end
	endtask

	// Output side: random stalls, compare each transfer with the oldest entry.
	initial begin
		out_item_t got, exp_v;
		int gap;
		bit vld;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 16)) : 0;
			if (gap > 0) begin
				pix_out.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pix_out.ready <= 1'b1;
			// valid and data only move at the rising edge: read them ahead of it
			forever begin
				vld = pix_out.valid;
				got = pix_out.data;
				@(posedge clk);
				if (vld) break;
				@(negedge clk);
			end
			if (blur_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) $display("unexpected result with nothing pending");
			end else begin
				exp_v = blur_q.pop_front();
				if (got !== exp_v) note_mismatch(exp_v, got);
			end
			@(negedge clk);
		end
	end

	// Watchdog: cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIM) begin
			timed_out = 1'b1;
			$display("gaussian_window_convolver_tb: done, errors");
			$finish;
		end
	end

	initial begin
		drow_t dir [$];
		drow_t row;
		in_item_t it;
		int cols, rows;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		err_cnt = 0; idle_cycles = 0; in_sent = 0; timed_out = 0;
		img_cols = 11'd1024; img_rows = 13'd768;
		wgt[0] = 16'hffff;
		for (int k = 1; k < 6; k++) wgt[k] = '0;
		for (int k = 0; k < RING; k++) pix_ring[k] = '0;
		pos_col = 0; pos_row = 0; done_cnt = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: 1x1 image, identity-ish weights, extremes of every channel.
		cfg_write(CFG_IMAGE_COLS, 16'd1);
		cfg_write(CFG_IMAGE_ROWS, 16'd1);
		// 1x1 with reset weights: 0xff * 0xffff >> 16 = 0xfe; zero stays zero
		row.item = '{1'b0, 8'hff, 8'hff, 8'hff, 8'hff};
		row.has_exp = 1; row.exp_res = '{8'hfe, 8'hfe, 8'hfe, 8'hfe, 1'b1};
		dir.push_back(row);
		row.item = '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00};
		row.exp_res = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
		dir.push_back(row);
		row.item = '{1'b0, 8'h80, 8'h01, 8'h7f, 8'hfe};
		row.exp_res = '{8'h7f, 8'h00, 8'h7e, 8'hfd, 1'b1};
		dir.push_back(row);
		for (int k = 0; k < dir.size(); k++) begin
			send_item(dir[k].item, 1'b0);
			// step past the end until the result is due
			it = '0; it.req_type = 1'b1;
			while (done_cnt != 0 || pos_col != 0 || pos_row != 0) send_item(it, 1'b0);
			if (dir[k].has_exp && blur_q.size() != 0)
				blur_q[blur_q.size() - 1] = dir[k].exp_res;
			wait_drained();
		end

		// Saturation: all weights maximal on a 3x3 image of bright pixels.
		cfg_write(CFG_IMAGE_COLS, 16'd3);
		cfg_write(CFG_IMAGE_ROWS, 16'd3);
		cfg_write(CFG_WEIGHT_D1, 16'hffff);
		cfg_write(CFG_WEIGHT_D2, 16'hffff);
		cfg_write(CFG_WEIGHT_D4, 16'hffff);
		cfg_write(CFG_WEIGHT_D5, 16'hffff);
		cfg_write(CFG_WEIGHT_D8, 16'hffff);
		for (int k = 0; k < 9; k++) send_item('{1'b0, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0);
		it = '0; it.req_type = 1'b1;
		while (done_cnt != 0 || pos_col != 0 || pos_row != 0) send_item(it, 1'b0);
		wait_drained();

		// Random part: small random images, random weights, zero weights too.
		while (in_sent < 450 && !timed_out) begin
			case ($urandom_range(0, 5))
				0: begin cols = 1; rows = $urandom_range(1, 6); end
				1: begin cols = $urandom_range(1, 6); rows = 1; end
				default: begin cols = $urandom_range(2, 9); rows = $urandom_range(2, 7); end
			endcase
			cfg_write(CFG_IMAGE_COLS, 16'(cols));
			cfg_write(CFG_IMAGE_ROWS, 16'(rows));
			cfg_write(CFG_WEIGHT_D0, ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom));
			cfg_write(CFG_WEIGHT_D1, 16'($urandom_range(0, 16'h3fff)));
			cfg_write(CFG_WEIGHT_D2, 16'($urandom_range(0, 16'h1fff)));
			cfg_write(CFG_WEIGHT_D4, 16'($urandom_range(0, 16'h0fff)));
			cfg_write(CFG_WEIGHT_D5, ($urandom_range(0, 7) == 0) ? 16'hffff
				: 16'($urandom_range(0, 16'h0fff)));
			cfg_write(CFG_WEIGHT_D8, 16'($urandom_range(0, 16'h07ff)));
			run_image(cols, rows);
			// hold the sender until every result is back
			wait_drained();
		end

		while (blur_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (err_cnt == 0)
			$display("gaussian_window_convolver_tb: done, clean");
		else
			$display("gaussian_window_convolver_tb: done, errors");
		$finish;
	end

endmodule
